>>> rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types for the byte ring FIFO
// Item layouts on both channels, the queued command and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int BYTE_W = 8;   // stored byte
  localparam int LEN_W  = 7;   // read limit and bytes returned
  localparam int CFG_W  = 9;   // capacity register

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] put_byte;
    logic [LEN_W-1:0]  read_limit;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
    logic [LEN_W-1:0]  bytes_read;
  } out_item_t;

  // Classified command held between front and back
  typedef struct packed {
    logic              is_read;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  limit;   // already clamped to the read maximum
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front: input acceptance, classification and command queue
// Decodes each item into a command and holds up to two for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_front #(
  parameter int MAX_READ = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire brf_pkg::in_item_t in_data,
  output      logic             q_valid,
  output      brf_pkg::cmd_t    q_cmd,
  input  wire logic             q_pop
);

  import brf_pkg::*;

  cmd_t       q_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  // Classify: decode opcode, clamp the read limit
  always_comb begin
    cmd_in.is_read = (in_data.opcode == OP_READ);
    cmd_in.data    = in_data.put_byte;
    cmd_in.limit   = (in_data.read_limit > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ)
                                                             : in_data.read_limit;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = ~tail_r;
    end
    if (q_pop) begin
      head_nxt = ~head_r;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back: command execution and result output
// Owns the positions, the fill count, the byte store and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_back #(
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [$clog2(DEPTH+1)-1:0]  cap_eff,
  input  wire logic                        cfg_clr,
  input  wire logic                        q_valid,
  input  wire brf_pkg::cmd_t               q_cmd,
  output      logic                        q_pop,
  output      logic                        busy,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      brf_pkg::out_item_t          out_data
);

  import brf_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = (CW > LEN_W) ? CW : LEN_W;

  back_state_t      state_r, state_nxt;
  logic [PW-1:0]    rd_pos_r, rd_pos_nxt;
  logic [PW-1:0]    wr_pos_r, wr_pos_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_bv_r, out_bv_nxt;
  logic             out_last_r, out_last_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;

  logic [CW-1:0]    wr_inc, rd_inc;
  logic [PW-1:0]    wr_adv, rd_adv;
  logic [NW-1:0]    lim_ext, cnt_ext;
  logic [LEN_W-1:0] n_rd;
  logic             out_free;
  logic             ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  // Next positions, wrapping at the capacity in use
  always_comb begin
    wr_inc  = CW'(wr_pos_r) + CW'(1);
    rd_inc  = CW'(rd_pos_r) + CW'(1);
    wr_adv  = (wr_inc >= cap_eff) ? '0 : wr_inc[PW-1:0];
    rd_adv  = (rd_inc >= cap_eff) ? '0 : rd_inc[PW-1:0];
    lim_ext = NW'(q_cmd.limit);
    cnt_ext = NW'(cnt_r);
    n_rd    = (lim_ext < cnt_ext) ? q_cmd.limit : cnt_ext[LEN_W-1:0];
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    rd_pos_nxt    = rd_pos_r;
    wr_pos_nxt    = wr_pos_r;
    cnt_nxt       = cnt_r;
    remain_nxt    = remain_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (!q_cmd.is_read) begin
            // Put: store, advance write side, drop oldest when full
            q_pop      = 1'b1;
            ram_we     = 1'b1;
            wr_pos_nxt = wr_adv;
            if (cnt_r >= cap_eff) begin
              rd_pos_nxt = rd_adv;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (n_rd != '0) begin
            q_pop      = 1'b1;
            remain_nxt = n_rd;
            total_nxt  = n_rd;
            state_nxt  = BK_READ;
          end else if (out_free) begin
            // Empty read: one marker result
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            out_bv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_len_nxt   = '0;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          ram_re        = 1'b1;
          out_valid_nxt = 1'b1;
          out_bv_nxt    = 1'b1;
          out_last_nxt  = (remain_r == LEN_W'(1));
          out_len_nxt   = total_r;
          rd_pos_nxt    = rd_adv;
          cnt_nxt       = cnt_r - CW'(1);
          remain_nxt    = remain_r - LEN_W'(1);
          if (remain_r == LEN_W'(1)) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (cfg_clr) begin
      rd_pos_nxt = '0;
      wr_pos_nxt = '0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r   <= remain_nxt;
    total_r    <= total_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (q_cmd.data),
    .re    (ram_re),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  assign busy                = (state_r != BK_IDLE) || out_valid_r;
  assign out_valid           = out_valid_r;
  assign out_data.read_byte  = out_bv_r ? ram_rdata : '0;
  assign out_data.byte_valid = out_bv_r;
  assign out_data.last       = out_last_r;
  assign out_data.bytes_read = out_len_r;

endmodule

`default_nettype wire

>>> rtl/byte_ring_fifo_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite: circular byte FIFO that overwrites its oldest byte
// Puts store bytes; reads stream up to a limit of bytes, oldest first.
// ----------------------------------------------------------------------------
// Puts: one per cycle sustained while no read holds the back end; no result.
// Reads of n bytes: a setup step, then one byte per cycle while the sink does
//   not stall, paced by the single read port of the byte store; an empty read gives one marker result.
// The first byte of a read passes the front queue, the back-end read state and the registered store read.
// Reset: positions and fill count cleared, capacity = min(256, DEPTH); the
//   byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_overwrite #(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire brf_pkg::in_item_t         in_data,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      brf_pkg::out_item_t        out_data,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [brf_pkg::CFG_W-1:0] cfg_data
);

  import brf_pkg::*;

  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CW > CFG_W) ? CW : CFG_W;
  localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

  logic          q_valid;
  cmd_t          q_cmd;
  logic          q_pop;
  logic          back_busy;
  logic          cfg_wr;
  logic [CW-1:0] cap_eff_r, cap_eff_nxt;
  logic [CMP_W-1:0] cfg_ext;

  // Take a capacity write only when nothing is queued or in flight
  assign cfg_ready = !back_busy && !q_valid;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Clamp the written capacity into 1..DEPTH once, at the transfer
  always_comb begin
    cfg_ext     = CMP_W'(cfg_data);
    cap_eff_nxt = cap_eff_r;
    if (cfg_wr) begin
      if (cfg_ext == '0) begin
        cap_eff_nxt = CW'(1);
      end else if (cfg_ext > CMP_W'(DEPTH)) begin
        cap_eff_nxt = CW'(DEPTH);
      end else begin
        cap_eff_nxt = cfg_ext[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_eff_r <= CW'(CAP_RST);
    end else begin
      cap_eff_r <= cap_eff_nxt;
    end
  end

  // Front: accept, classify, queue
  brf_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // Back: execute puts and reads, drive results; a capacity write empties it
  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_eff   (cap_eff_r),
    .cfg_clr   (cfg_wr),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> dv/brf_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brf_stream_checker: result checker for the overwriting byte ring FIFO
// Watches the put/read, result and capacity channels. It keeps its own copy
// of the ring and predicts each read's byte stream. Every result transfer is
// compared field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------

module brf_stream_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  brf_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  brf_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [brf_pkg::CFG_W-1:0]   cfg_data,
  output int                          mismatch_count,
  output int                          pending_results,
  output int                          results_checked
);
  import brf_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int READ_MAX   = 64;

  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  logic [7:0]        head_pos;
  logic [7:0]        tail_pos;
  logic [8:0]        fill_level;
  logic [CFG_W-1:0]  capacity_reg;
  out_item_t         expected_bytes [$];
  int                errors;
  int                checked;

  // Register value 0 behaves as 1, anything above the ring depth as the depth
  function automatic logic [8:0] usable_capacity();
    if (capacity_reg == '0) return 9'd1;
    if (capacity_reg > RING_DEPTH) return 9'(RING_DEPTH);
    return capacity_reg;
  endfunction

  function automatic logic [7:0] wrap_pos(input logic [7:0] pos, input logic [8:0] cap);
    return ({1'b0, pos} >= cap) ? 8'd0 : pos;
  endfunction

  function automatic logic [7:0] next_pos(input logic [7:0] pos, input logic [8:0] cap);
    logic [8:0] nxt;
    nxt = {1'b0, pos} + 9'd1;
    return (nxt >= cap) ? 8'd0 : nxt[7:0];
  endfunction

  task automatic predict_ring_item(input in_item_t item);
    logic [8:0]       cap;
    logic [7:0]       pos;
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] n;
    out_item_t        res;
    int               k;
    cap = usable_capacity();
    if (item.opcode == OP_PUT) begin
      pos = wrap_pos(tail_pos, cap);
      ring_bytes[pos] = item.put_byte;
      tail_pos = next_pos(pos, cap);
      // Full ring: drop the oldest byte, level stays put
      if (fill_level >= cap) begin
        fill_level = cap;
        head_pos = next_pos(wrap_pos(head_pos, cap), cap);
      end else begin
        fill_level = fill_level + 9'd1;
      end
    end else begin
      lim = (item.read_limit > READ_MAX) ? LEN_W'(READ_MAX) : item.read_limit;
      n = ({2'b00, lim} < fill_level) ? lim : fill_level[LEN_W-1:0];
      if (n == '0) begin
        res.read_byte  = '0;
        res.byte_valid = 1'b0;
        res.last       = 1'b1;
        res.bytes_read = '0;
        expected_bytes.push_back(res);
      end else begin
        pos = wrap_pos(head_pos, cap);
        for (k = 0; k < n; k++) begin
          res.read_byte  = ring_bytes[pos];
          res.byte_valid = 1'b1;
          res.last       = (k + 1 == n);
          res.bytes_read = n;
          expected_bytes.push_back(res);
          pos = next_pos(pos, cap);
        end
        head_pos = pos;
        fill_level = fill_level - {2'b00, n};
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: read_byte %0d byte_valid %0d last %0d bytes_read %0d",
             got.read_byte, got.byte_valid, got.last, got.bytes_read);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    checked++;
    if (got.read_byte !== want.read_byte) begin
      $error("read_byte: expected %0d, actual %0d", want.read_byte, got.read_byte);
      errors++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0d, actual %0d", want.byte_valid, got.byte_valid);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
    if (got.bytes_read !== want.bytes_read) begin
      $error("bytes_read: expected %0d, actual %0d", want.bytes_read, got.bytes_read);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      head_pos     = '0;
      tail_pos     = '0;
      fill_level   = '0;
      capacity_reg = 9'd256;
      expected_bytes.delete();
    end else begin
      // Results first: a result can never belong to an item taken this cycle
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        capacity_reg = cfg_data;
        head_pos     = '0;
        tail_pos     = '0;
        fill_level   = '0;
      end
      if (in_valid && !in_stall) predict_ring_item(in_data);
    end
    mismatch_count  <= errors;
    pending_results <= expected_bytes.size();
    results_checked <= checked;
  end

endmodule

>>> dv/byte_ring_fifo_overwrite_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite_test: stimulus and verdict for the byte ring FIFO
// Drives puts and reads with random gaps against a randomly stalling result
// sink, across several ring capacities, and lets brf_stream_checker compare
// every streamed byte. Includes a long sink hold-off to back up the block.
// ----------------------------------------------------------------------------

module byte_ring_fifo_overwrite_test;
  import brf_pkg::*;

  localparam int SETTLE_CYCLES  = 8;     // margin after the last predicted result
  localparam int HOLD_CYCLES    = 150;   // long sink hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int mismatch_count;
  int pending_results;
  int results_checked;

  // Knobs shared between the sender and the sink
  int   gap_pct   = 0;
  int   stall_pct = 0;
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;

  int puts_sent  = 0;
  int reads_sent = 0;
  int cap_writes = 0;
  int idle_cycles;

  byte_ring_fifo_overwrite dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  brf_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random item: the opcode split is set by the phase. The limit leans to
  // short reads but also hits zero and values above the read maximum.
  // The field that the opcode ignores is random as well.
  function automatic in_item_t random_item(input int put_pct);
    in_item_t item;
    int       pick;
    item.opcode   = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_READ;
    item.put_byte = BYTE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      item.read_limit = '0;
    else if (pick <= 2)
      item.read_limit = LEN_W'($urandom_range(65, 127));
    else if (pick <= 11)
      item.read_limit = LEN_W'($urandom_range(1, 8));
    else
      item.read_limit = LEN_W'($urandom_range(9, 64));
    return item;
  endfunction

  // Offer one item and hold it until the block takes the transfer.
  // An optional gap in front lowers valid for a random burst.
  task automatic offer_item(input in_item_t item);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (item.opcode == OP_PUT) puts_sent++;
    else reads_sent++;
  endtask

  task automatic send_put(input logic [BYTE_W-1:0] value);
    in_item_t item;
    item.opcode     = OP_PUT;
    item.put_byte   = value;
    item.read_limit = LEN_W'($urandom_range(0, 127));
    offer_item(item);
  endtask

  task automatic send_read(input logic [LEN_W-1:0] limit);
    in_item_t item;
    item.opcode     = OP_READ;
    item.put_byte   = BYTE_W'($urandom_range(0, 255));
    item.read_limit = limit;
    offer_item(item);
  endtask

  // Wait for every predicted byte, then give a trailing put time to land
  task automatic drain_results();
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity writes happen only with the block idle; each one empties the ring
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    drain_results();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int count,
                           input int put_pct, input int gaps, input int stalls);
    write_capacity(cap);
    gap_pct = gaps;
    stall_pct <= stalls;
    repeat (count) offer_item(random_item(put_pct));
  endtask

  // Result sink: random stall bursts, plus one long hold-off on request.
  // Nothing stalls once the calm tail of the run starts.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset capacity, empty reads, byte extremes, clamped limit
    send_read(7'd5);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'hA5);
    send_read(7'd0);
    send_read(7'd127);
    send_put(8'h5A);
    send_read(7'd1);
    send_read(7'd64);

    // Register value zero acts as a one-byte ring; each put after the first overwrites
    write_capacity(9'd0);
    send_put(8'h11);
    send_put(8'h22);
    send_put(8'h33);
    send_read(7'd64);

    // Three-byte ring: overwrite, then read across the wrap point
    write_capacity(9'd3);
    send_put(8'h01);
    send_put(8'h02);
    send_put(8'h03);
    send_put(8'h04);
    send_put(8'h05);
    send_read(7'd2);
    send_put(8'h06);
    send_read(7'd64);

    // All ones in the register clamps to the full ring depth
    write_capacity(9'd511);
    send_put(8'h80);
    send_read(7'd1);

    // Random phases over small rings
    run_phase(9'd2, 20, 60, 25, 25);
    run_phase(9'd1, 15, 50, 10, 40);

    // Sender pauses mid-phase until every result is back
    run_phase(9'd17, 20, 70, 0, 0);
    in_valid <= 1'b0;
    drain_results();
    gap_pct = 25;
    stall_pct <= 15;
    repeat (20) offer_item(random_item(55));

    // Load the ring with puts, then hold the sink off while reads keep coming so the
    // result path backs up and the block stalls its input
    run_phase(9'd100, 30, 100, 0, 0);
    hold_req <= 1'b1;
    repeat (20) offer_item(random_item(30));

    run_phase(9'd300, 20, 80, 20, 20);
    run_phase(CFG_W'($urandom_range(3, 255)), 20, 65, 30, 30);

    // Calm tail: no gaps and no stalls
    calm <= 1'b1;
    run_phase(9'd256, 25, 70, 0, 0);
    in_valid <= 1'b0;
    drain_results();

    $display("Covered %0d puts and %0d reads over %0d capacity writes; %0d results checked,",
             puts_sent, reads_sent, cap_writes, results_checked);
    $display("including ring overwrite, wrap, empty and clamped reads, and a long sink hold-off.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_front.sv
rtl/brf_back.sv
rtl/byte_ring_fifo_overwrite.sv
dv/brf_stream_checker.sv
dv/byte_ring_fifo_overwrite_test.sv
